// ----- design/gvr_pkg.sv -----
// shared types and constants of the garch variance recursion core
package gvr_pkg;

  localparam int unsigned DATA_WIDTH    = 32;
  localparam int unsigned COEF_W        = 19;
  localparam int unsigned ORDER_W       = 2;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned MAX_ORDER_DEF = 2;

  localparam logic signed [COEF_W+2:0] ONE_Q16 = 22'sd65536;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OMEGA = 3'd1,
    ST_ARCH  = 3'd2,
    ST_GARCH = 3'd3,
    ST_SUM   = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OMEGA        = 3'd0,
    CFG_BACKCAST     = 3'd1,
    CFG_ARCH_ORDER   = 3'd2,
    CFG_GARCH_ORDER  = 3'd3,
    CFG_ARCH_COEF_1  = 3'd4,
    CFG_ARCH_COEF_2  = 3'd5,
    CFG_GARCH_COEF_1 = 3'd6,
    CFG_GARCH_COEF_2 = 3'd7
  } cfg_idx_e;

endpackage

// ----- design/gvr_if.sv -----
// valid/ready channel interfaces for samples, variances and register writes
interface gvr_in_if;
  logic                            valid;
  logic                            ready;
  logic [gvr_pkg::DATA_WIDTH-1:0]  squared_residual;
  logic                            last_in_series;

  modport source (output valid, output squared_residual, output last_in_series,
                  input ready);
  modport sink   (input valid, input squared_residual, input last_in_series,
                  output ready);
endinterface

interface gvr_out_if;
  logic                            valid;
  logic                            ready;
  logic [gvr_pkg::DATA_WIDTH-1:0]  cond_variance;
  gvr_pkg::status_e                status;

  modport source (output valid, output cond_variance, output status, input ready);
  modport sink   (input valid, input cond_variance, input status, output ready);
endinterface

interface gvr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gvr_pkg::CFG_IDX_W-1:0]   index;
  logic [gvr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/garch_variance_recursion_core.sv -----
// garch(p,q) conditional variance recursion core
// One sample is taken every clock cycle unless the output stalls, and a variance
// leaves through the input register, then the result register. The rate is set by the
// recursion loop: each variance is built combinationally by the multiply-add from the
// history registers to the result register, and feeds the next sample's sum at once.
// The result register and the input register decouple the two sides, so a stalled
// output still lets one more sample in. Register writes are taken every cycle.
module garch_variance_recursion_core #(
  parameter int unsigned MAX_ORDER = gvr_pkg::MAX_ORDER_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gvr_cfg_if.sink           cfg_i,
  gvr_in_if.sink            in_i,
  gvr_out_if.source         out_o
);
  import gvr_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ORDER + 1);
  localparam int unsigned HIST_D = (MAX_ORDER < 2) ? MAX_ORDER : 2;
  localparam int unsigned PROD_W = FRAC_W + 1 + DATA_WIDTH;
  localparam int unsigned ACC_W  = PROD_W + 3;
  localparam int unsigned RND_W  = ACC_W - FRAC_W;

  // configuration registers
  logic signed [DATA_WIDTH-1:0] omega_q;
  logic [DATA_WIDTH-1:0]        backcast_q;
  logic [ORDER_W-1:0]           arch_order_q;
  logic [ORDER_W-1:0]           garch_order_q;
  logic signed [COEF_W-1:0]     arch_coef_q [2];
  logic signed [COEF_W-1:0]     garch_coef_q [2];

  // pipeline and history
  logic                  s1_valid_q;
  logic [DATA_WIDTH-1:0] s1_resid_q;
  logic                  s1_last_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_var_q;
  status_e               out_status_q;
  logic [DATA_WIDTH-1:0] resid_hist_q [HIST_D];
  logic [DATA_WIDTH-1:0] var_hist_q [HIST_D];
  logic [CNT_W-1:0]      samples_seen_q;

  logic                     adv;
  logic [CNT_W-1:0]         p_ord;
  logic [CNT_W-1:0]         q_ord;
  logic [CNT_W-1:0]         lag;
  logic [HIST_D-1:0]        a_use;
  logic [HIST_D-1:0]        g_use;
  logic                     arch_neg;
  logic                     garch_neg;
  logic signed [COEF_W+2:0] coef_sum;
  status_e                  status_d;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         rnd;
  logic [RND_W-1:0]         h_wide;
  logic [DATA_WIDTH-1:0]    h_sat;
  logic [DATA_WIDTH-1:0]    var_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q         <= DATA_WIDTH'(1);
      backcast_q      <= DATA_WIDTH'(65536);
      arch_order_q    <= ORDER_W'(1);
      garch_order_q   <= ORDER_W'(1);
      arch_coef_q[0]  <= COEF_W'(6554);
      arch_coef_q[1]  <= '0;
      garch_coef_q[0] <= COEF_W'(58982);
      garch_coef_q[1] <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_OMEGA:        omega_q         <= cfg_i.data[DATA_WIDTH-1:0];
        CFG_BACKCAST:     backcast_q      <= cfg_i.data[DATA_WIDTH-1:0];
        CFG_ARCH_ORDER:   arch_order_q    <= cfg_i.data[ORDER_W-1:0];
        CFG_GARCH_ORDER:  garch_order_q   <= cfg_i.data[ORDER_W-1:0];
        CFG_ARCH_COEF_1:  arch_coef_q[0]  <= cfg_i.data[COEF_W-1:0];
        CFG_ARCH_COEF_2:  arch_coef_q[1]  <= cfg_i.data[COEF_W-1:0];
        CFG_GARCH_COEF_1: garch_coef_q[0] <= cfg_i.data[COEF_W-1:0];
        CFG_GARCH_COEF_2: garch_coef_q[1] <= cfg_i.data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv          = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready   = !s1_valid_q || adv;
  assign out_o.valid  = out_valid_q;
  assign out_o.cond_variance = out_var_q;
  assign out_o.status = out_status_q;

  // effective orders and parameter check
  always_comb begin
    p_ord = (32'(arch_order_q) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(arch_order_q);
    q_ord = (32'(garch_order_q) > MAX_ORDER) ? CNT_W'(MAX_ORDER) : CNT_W'(garch_order_q);
    lag   = (p_ord > q_ord) ? p_ord : q_ord;
    arch_neg  = 1'b0;
    garch_neg = 1'b0;
    coef_sum  = '0;
    for (int k = 0; k < HIST_D; k++) begin
      a_use[k] = int'(p_ord) > k;
      g_use[k] = int'(q_ord) > k;
      if (a_use[k]) begin
        arch_neg = arch_neg | arch_coef_q[k][COEF_W-1];
        coef_sum = coef_sum + (COEF_W+3)'(arch_coef_q[k]);
      end
      if (g_use[k]) begin
        garch_neg = garch_neg | garch_coef_q[k][COEF_W-1];
        coef_sum = coef_sum + (COEF_W+3)'(garch_coef_q[k]);
      end
    end
    if (omega_q[DATA_WIDTH-1] || (omega_q == '0)) begin
      status_d = ST_OMEGA;
    end else if (arch_neg) begin
      status_d = ST_ARCH;
    end else if (garch_neg) begin
      status_d = ST_GARCH;
    end else if (coef_sum != ONE_Q16) begin
      status_d = ST_SUM;
    end else begin
      status_d = ST_OK;
    end
  end

  // multiply-add, weights are at most 1.0 once the check passes
  always_comb begin
    acc = ACC_W'({omega_q[DATA_WIDTH-2:0], {FRAC_W{1'b0}}});
    for (int k = 0; k < HIST_D; k++) begin
      if (a_use[k]) begin
        acc = acc + ACC_W'(PROD_W'(arch_coef_q[k][FRAC_W:0]) * PROD_W'(resid_hist_q[k]));
      end
      if (g_use[k]) begin
        acc = acc + ACC_W'(PROD_W'(garch_coef_q[k][FRAC_W:0]) * PROD_W'(var_hist_q[k]));
      end
    end
    rnd    = acc + ACC_W'(1 << (FRAC_W - 1));
    h_wide = rnd[ACC_W-1:FRAC_W];
    if (|h_wide[RND_W-1:DATA_WIDTH]) begin
      h_sat = '1;
    end else if (h_wide == '0) begin
      h_sat = DATA_WIDTH'(1);
    end else begin
      h_sat = h_wide[DATA_WIDTH-1:0];
    end
    if (status_d != ST_OK) begin
      var_d = '0;
    end else if (samples_seen_q < lag) begin
      var_d = backcast_q;
    end else begin
      var_d = h_sat;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_resid_q <= in_i.squared_residual;
      s1_last_q  <= in_i.last_in_series;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_var_q    <= var_d;
      out_status_q <= status_d;
    end
  end

  // history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_seen_q <= '0;
      for (int k = 0; k < HIST_D; k++) begin
        resid_hist_q[k] <= '0;
        var_hist_q[k]   <= '0;
      end
    end else if (adv) begin
      if (s1_last_q) begin
        samples_seen_q <= '0;
        for (int k = 0; k < HIST_D; k++) begin
          resid_hist_q[k] <= '0;
          var_hist_q[k]   <= '0;
        end
      end else if (status_d == ST_OK) begin
        for (int k = HIST_D - 1; k > 0; k--) begin
          resid_hist_q[k] <= resid_hist_q[k-1];
          var_hist_q[k]   <= var_hist_q[k-1];
        end
        resid_hist_q[0] <= s1_resid_q;
        var_hist_q[0]   <= var_d;
        if (32'(samples_seen_q) < MAX_ORDER) begin
          samples_seen_q <= samples_seen_q + CNT_W'(1);
        end
      end
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_OK)) |-> (out_o.cond_variance == '0))
    else $error("variance not zero on a failed parameter check");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_last_q) |=> (samples_seen_q == '0))
    else $error("series end did not clear the history");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
    else $error("input stalled while a stage was free");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(samples_seen_q) <= MAX_ORDER)
    else $error("sample count beyond the maximum order");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the garch variance recursion core
`timescale 1ns / 1ps

module tb_top;
  import gvr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_END  = 1722;
  localparam int unsigned NUM_ROWS    = 46;
  localparam logic [63:0] DATA_MAX    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] cond_variance;
    status_e               status;
  } variance_t;

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef enum int {FAULT_OMEGA, FAULT_ARCH, FAULT_GARCH, FAULT_SUM, FAULT_NONE} fault_e;

  typedef struct {
    row_kind_e             kind;
    cfg_idx_e              idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  last_flag;
    bit                    known;
    logic [DATA_WIDTH-1:0] known_var;
    status_e               known_st;
  } row_t;

  logic clk_i;
  logic rst_ni;

  gvr_cfg_if cfg_if ();
  gvr_in_if  in_if ();
  gvr_out_if out_if ();

  garch_variance_recursion_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // register copies and recursion history
  logic signed [CFG_DATA_W-1:0] cfg_omega    = 32'sd1;
  logic [DATA_WIDTH-1:0]        cfg_backcast = 32'd65536;
  logic [ORDER_W-1:0]           cfg_arch_order  = 2'd1;
  logic [ORDER_W-1:0]           cfg_garch_order = 2'd1;
  logic signed [COEF_W-1:0]     cfg_arch_w  [MAX_ORDER_DEF] = '{19'sd6554, 19'sd0};
  logic signed [COEF_W-1:0]     cfg_garch_w [MAX_ORDER_DEF] = '{19'sd58982, 19'sd0};
  logic [DATA_WIDTH-1:0]        resid_hist [MAX_ORDER_DEF] = '{default: '0};
  logic [DATA_WIDTH-1:0]        var_hist   [MAX_ORDER_DEF] = '{default: '0};
  int unsigned                  n_seen = 0;

  variance_t   pending_variances [$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  row_t directed_rows [NUM_ROWS] = '{
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0001_0000, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0001_2345, 1'b1, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0005, 1'b0, 1'b1, 32'h0001_0000, ST_OK},
    '{ROW_WRITE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0007, 1'b0, 1'b1, 32'h0, ST_OMEGA},
    '{ROW_WRITE, CFG_OMEGA, 32'h8000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, ST_OMEGA},
    '{ROW_WRITE, CFG_OMEGA, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_ARCH_COEF_1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0001, 1'b0, 1'b1, 32'h0, ST_ARCH},
    '{ROW_WRITE, CFG_ARCH_COEF_1, 32'h0000_199A, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_COEF_1, 32'hFFFE_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0002, 1'b0, 1'b1, 32'h0, ST_GARCH},
    '{ROW_WRITE, CFG_GARCH_COEF_1, 32'h0002_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0003, 1'b0, 1'b1, 32'h0, ST_SUM},
    '{ROW_WRITE, CFG_ARCH_ORDER, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_ORDER, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0004, 1'b0, 1'b1, 32'h0, ST_SUM},
    '{ROW_WRITE, CFG_ARCH_ORDER, 32'h0000_0003, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_ORDER, 32'h0000_0003, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_ARCH_COEF_1, 32'h0001_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_COEF_1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_BACKCAST, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_OK},
    '{ROW_WRITE, CFG_ARCH_COEF_2, 32'hFFFE_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_ARCH},
    '{ROW_WRITE, CFG_ARCH_COEF_2, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_COEF_2, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_GARCH},
    '{ROW_WRITE, CFG_OMEGA, 32'h0000_0001, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_BACKCAST, 32'h0000_0001, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_ARCH_COEF_1, 32'h0000_4000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_ARCH_COEF_2, 32'h0000_4000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_COEF_1, 32'h0000_4000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_COEF_2, 32'h0000_4000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h8000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_FFFF, 1'b1, 1'b0, 32'h0, ST_OK},
    '{ROW_WRITE, CFG_GARCH_ORDER, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
    '{ROW_SAMPLE, CFG_OMEGA, 32'h0000_0000, 1'b0, 1'b1, 32'h0, ST_SUM}
  };

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic variance_t recurse_variance(input logic [DATA_WIDTH-1:0] resid,
                                                 input logic last_flag);
    variance_t   res;
    int unsigned p;
    int unsigned q;
    int unsigned lag;
    int          weight_sum;
    logic [63:0] acc;
    logic [63:0] h;
    p = (cfg_arch_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : cfg_arch_order;
    q = (cfg_garch_order > MAX_ORDER_DEF) ? MAX_ORDER_DEF : cfg_garch_order;
    lag = (p > q) ? p : q;
    res.status = ST_OK;
    res.cond_variance = '0;
    weight_sum = 0;
    h = '0;
    if (cfg_omega <= 0) res.status = ST_OMEGA;
    for (int i = 0; i < p; i++) begin
      if (res.status == ST_OK && cfg_arch_w[i] < 0) res.status = ST_ARCH;
      weight_sum += cfg_arch_w[i];
    end
    for (int i = 0; i < q; i++) begin
      if (res.status == ST_OK && cfg_garch_w[i] < 0) res.status = ST_GARCH;
      weight_sum += cfg_garch_w[i];
    end
    if (res.status == ST_OK && weight_sum != 65536) res.status = ST_SUM;
    if (res.status == ST_OK) begin
      if (n_seen < lag) begin
        h = {32'd0, cfg_backcast};
      end else begin
        acc = {32'd0, cfg_omega} << FRAC_W;
        for (int i = 0; i < p; i++) acc += {45'd0, cfg_arch_w[i]} * {32'd0, resid_hist[i]};
        for (int i = 0; i < q; i++) acc += {45'd0, cfg_garch_w[i]} * {32'd0, var_hist[i]};
        h = (acc + 64'd32768) >> FRAC_W;
        if (h == 0) h = 64'd1;
        if (h > DATA_MAX) h = DATA_MAX;
      end
      res.cond_variance = h[DATA_WIDTH-1:0];
      for (int i = MAX_ORDER_DEF - 1; i > 0; i--) begin
        resid_hist[i] = resid_hist[i-1];
        var_hist[i] = var_hist[i-1];
      end
      resid_hist[0] = resid;
      var_hist[0] = h[DATA_WIDTH-1:0];
      if (n_seen < MAX_ORDER_DEF) n_seen++;
    end
    if (last_flag) begin
      for (int i = 0; i < MAX_ORDER_DEF; i++) begin
        resid_hist[i] = '0;
        var_hist[i] = '0;
      end
      n_seen = 0;
    end
    return res;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_OMEGA:        cfg_omega = value;
      CFG_BACKCAST:     cfg_backcast = value;
      CFG_ARCH_ORDER:   cfg_arch_order = value[ORDER_W-1:0];
      CFG_GARCH_ORDER:  cfg_garch_order = value[ORDER_W-1:0];
      CFG_ARCH_COEF_1:  cfg_arch_w[0] = value[COEF_W-1:0];
      CFG_ARCH_COEF_2:  cfg_arch_w[1] = value[COEF_W-1:0];
      CFG_GARCH_COEF_1: cfg_garch_w[0] = value[COEF_W-1:0];
      CFG_GARCH_COEF_2: cfg_garch_w[1] = value[COEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [DATA_WIDTH-1:0] resid, input logic last_flag,
                             input bit known, input variance_t known_exp);
    variance_t predicted;
    while (!(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 13) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.squared_residual <= resid;
    in_if.last_in_series   <= last_flag;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = recurse_variance(resid, last_flag);
    pending_variances.push_back(known ? known_exp : predicted);
    items_sent++;
  endtask

  task automatic drain_variances();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_variances.size() != 0);
  endtask

  // output side: random stalls, a clean stretch and one long hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 1100 && in_if.valid) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_if.ready <= 1'b0;
    end else if (results_seen >= 600 && results_seen < 900) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk_i) begin
    variance_t exp_v;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
      if (pending_variances.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual variance %h status %0d",
                 $time, out_if.cond_variance, out_if.status);
        mismatches++;
      end else begin
        exp_v = pending_variances.pop_front();
        if (out_if.cond_variance !== exp_v.cond_variance) begin
          $display("%0t: cond_variance mismatch, expected %h actual %h",
                   $time, exp_v.cond_variance, out_if.cond_variance);
          mismatches++;
        end
        if (out_if.status !== exp_v.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_v.status, out_if.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                    w [4];
    bit                    in_use [4];
    logic [CFG_DATA_W-1:0] regs [8];
    int unsigned           pe;
    int unsigned           qe;
    int unsigned           remaining;
    int unsigned           phase_len;
    int                    last_used;
    fault_e                fault;
    bit                    writing;
    variance_t             known_exp;
    logic [DATA_WIDTH-1:0] resid;

    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.squared_residual = '0;
    in_if.last_in_series = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_OMEGA;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    writing = 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (!writing) drain_variances();
        write_reg(directed_rows[r].idx, directed_rows[r].value);
        writing = 1'b1;
      end else begin
        if (writing) cfg_if.valid <= 1'b0;
        writing = 1'b0;
        known_exp.cond_variance = directed_rows[r].known_var;
        known_exp.status = directed_rows[r].known_st;
        send_sample(directed_rows[r].value, directed_rows[r].last_flag,
                    directed_rows[r].known, known_exp);
      end
    end

    known_exp = '0;
    while (items_sent < RANDOM_END) begin
      drain_variances();
      regs[CFG_ARCH_ORDER]  = $urandom_range(3);
      regs[CFG_GARCH_ORDER] = $urandom_range(3);
      pe = (regs[CFG_ARCH_ORDER] > MAX_ORDER_DEF) ? MAX_ORDER_DEF : regs[CFG_ARCH_ORDER];
      qe = (regs[CFG_GARCH_ORDER] > MAX_ORDER_DEF) ? MAX_ORDER_DEF : regs[CFG_GARCH_ORDER];
      for (int k = 0; k < 4; k++) w[k] = int'($urandom_range(262144)) - 131072;
      in_use = '{pe > 0, pe > 1, qe > 0, qe > 1};
      last_used = -1;
      for (int k = 0; k < 4; k++) if (in_use[k]) last_used = k;
      // split unity among the weights in use
      remaining = 65536;
      for (int k = 0; k < 4; k++) begin
        if (in_use[k]) begin
          if (k == last_used) begin
            w[k] = remaining;
          end else begin
            w[k] = $urandom_range(remaining);
            remaining -= w[k];
          end
        end
      end
      case ($urandom_range(9))
        0: regs[CFG_OMEGA] = 32'h0000_0001;
        1: regs[CFG_OMEGA] = 32'h7FFF_FFFF;
        default: regs[CFG_OMEGA] = $urandom_range(32'h0010_0000, 1);
      endcase
      regs[CFG_BACKCAST] = $urandom_range(32'hFFFF_FFFF, 1);
      remaining = $urandom_range(9);
      fault = (remaining < 4) ? fault_e'(remaining) : FAULT_NONE;
      case (fault)
        FAULT_OMEGA:
          regs[CFG_OMEGA] = ($urandom_range(1) != 0) ? '0 : -$urandom_range(32'h8000_0000, 1);
        FAULT_ARCH:
          if (pe > 0) w[$urandom_range(pe - 1)] = -int'($urandom_range(131072, 1));
        FAULT_GARCH:
          if (qe > 0) w[2 + $urandom_range(qe - 1)] = -int'($urandom_range(131072, 1));
        FAULT_SUM:
          if (last_used >= 0) w[last_used] += ($urandom_range(1) != 0) ? 1 : -1;
        default: ;
      endcase
      regs[CFG_ARCH_COEF_1]  = w[0];
      regs[CFG_ARCH_COEF_2]  = w[1];
      regs[CFG_GARCH_COEF_1] = w[2];
      regs[CFG_GARCH_COEF_2] = w[3];
      for (int k = 0; k < 8; k++) write_reg(cfg_idx_e'(k), regs[k]);
      cfg_if.valid <= 1'b0;

      phase_len = (fault == FAULT_NONE) ? $urandom_range(200, 30) : $urandom_range(25, 5);
      for (int n = 0; n < phase_len; n++) begin
        case ($urandom_range(9))
          0: resid = '0;
          1: resid = '1;
          2, 3, 4: resid = $urandom;
          default: resid = $urandom_range(32'h0010_0000);
        endcase
        send_sample(resid, $urandom_range(9) == 0, 1'b0, known_exp);
      end
    end

    drain_variances();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
